FILE: hw/rtl/tcw_pkg.sv
package tcw_pkg;

  // grid geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STEP = 8;
  localparam int CELLS    = COLUMNS * ROWS;

  // payload field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [7:0] RESET_ATTR = 8'h07;

  // control bytes
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;

  // request kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // register port
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CURRENT_ATTR = REG_IDX_W'(0);

  typedef struct packed {
    logic             kind;
    logic [7:0]       byte_in;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic             scrolled;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic init_wr;
    logic take;
    logic exec;
    logic row_clr;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic scroll;
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/tcw_cfg.sv
module tcw_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [7:0]                  cur_attr_o
);
  import tcw_pkg::*;

  logic [7:0]           attr_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_CURRENT_ATTR);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_CURRENT_ATTR) ? 32'(attr_q) : 32'h0;
  assign cur_attr_o = attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (wr_en) begin
      attr_q <= pwdata[7:0];
    end
  end

endmodule

FILE: hw/rtl/tcw_ctrl.sv
module tcw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tcw_pkg::sts_t sts_i,
  output tcw_pkg::cmd_t cmd_o
);
  import tcw_pkg::*;

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_EXEC  = 6'b000100,
    ST_CLEAR = 6'b001000,
    ST_RDATA = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_stall_o = 1'b1;
    case (state_q)
      ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_read) begin
          state_d = ST_RDATA;
        end else if (sts_i.scroll) begin
          state_d = ST_CLEAR;
        end else if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CLEAR: begin
        cmd_o.row_clr = 1'b1;
        if (sts_i.cnt_last) begin
          if (sts_i.out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RDATA, ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_DONE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/tcw_datapath.sv
module tcw_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcw_pkg::cmd_t      cmd_i,
  output tcw_pkg::sts_t      sts_o,
  input  tcw_pkg::in_item_t  in_data_i,
  input  logic [7:0]         cur_attr_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output tcw_pkg::out_item_t out_data_o
);
  import tcw_pkg::*;

  in_item_t         item_q;
  logic [COL_W-1:0] col_q, nxt_col, tgt_col, sel_col;
  logic [ROW_W-1:0] row_q, tgt_row, sel_row, top_q;
  logic [ROW_W:0]   nxt_row, phys_sum, phys_row, bot_sum, bot_row;
  logic [COL_W:0]   tab_col, inc_col;
  logic             wr_char_x, wr_attr_x, scroll, is_read, rd_in_range;
  logic             scrolled_q, rng_q;
  logic [ADDR_W-1:0] cnt_q, cell_addr, clr_addr, wa;
  logic             cnt_last;

  logic [7:0]       char_mem [CELLS];
  logic [7:0]       attr_mem [CELLS];
  logic [7:0]       wchar, wattr, rd_char_q, rd_attr_q;
  logic             we_char, we_attr, rd_en;

  out_item_t        out_d, out_q;
  logic             out_valid_q;

  assign is_read = (item_q.kind == KIND_READ);

  // cursor movement for a write request
  always_comb begin
    tab_col   = (COL_W+1)'((32'(col_q) / TAB_STEP + 1) * TAB_STEP);
    inc_col   = (COL_W+1)'(col_q) + (COL_W+1)'(1);
    nxt_col   = col_q;
    nxt_row   = (ROW_W+1)'(row_q);
    tgt_col   = col_q;
    tgt_row   = row_q;
    wr_char_x = 1'b0;
    wr_attr_x = 1'b0;
    case (item_q.byte_in)
      BYTE_BS: begin
        if (col_q != '0 || row_q != '0) begin
          if (col_q == '0) begin
            nxt_col = COL_W'(COLUMNS - 1);
            nxt_row = (ROW_W+1)'(row_q) - (ROW_W+1)'(1);
          end else begin
            nxt_col = col_q - COL_W'(1);
          end
          tgt_col   = nxt_col;
          tgt_row   = nxt_row[ROW_W-1:0];
          wr_char_x = 1'b1;
        end
      end
      BYTE_LF: begin
        nxt_col = '0;
        nxt_row = (ROW_W+1)'(row_q) + (ROW_W+1)'(1);
      end
      BYTE_TAB: begin
        if (tab_col >= (COL_W+1)'(COLUMNS)) begin
          nxt_col = '0;
          nxt_row = (ROW_W+1)'(row_q) + (ROW_W+1)'(1);
        end else begin
          nxt_col = tab_col[COL_W-1:0];
        end
      end
      BYTE_CR: begin
        nxt_col = '0;
      end
      default: begin
        wr_char_x = 1'b1;
        wr_attr_x = 1'b1;
        if (inc_col >= (COL_W+1)'(COLUMNS)) begin
          nxt_col = '0;
          nxt_row = (ROW_W+1)'(row_q) + (ROW_W+1)'(1);
        end else begin
          nxt_col = inc_col[COL_W-1:0];
        end
      end
    endcase
    scroll = !is_read && (nxt_row >= (ROW_W+1)'(ROWS));
  end

  // rows live in a ring: logical row r sits at physical row (r + top) mod ROWS
  always_comb begin
    sel_row  = is_read ? item_q.read_row : tgt_row;
    sel_col  = is_read ? item_q.read_col : tgt_col;
    phys_sum = (ROW_W+1)'(sel_row) + (ROW_W+1)'(top_q);
    phys_row = (phys_sum >= (ROW_W+1)'(ROWS)) ? phys_sum - (ROW_W+1)'(ROWS) : phys_sum;
    cell_addr = ADDR_W'(32'(phys_row) * COLUMNS) + ADDR_W'(sel_col);
    bot_sum  = (ROW_W+1)'(ROWS - 1) + (ROW_W+1)'(top_q);
    bot_row  = (bot_sum >= (ROW_W+1)'(ROWS)) ? bot_sum - (ROW_W+1)'(ROWS) : bot_sum;
    clr_addr = ADDR_W'(32'(bot_row) * COLUMNS) + cnt_q;
    rd_in_range = (item_q.read_row < ROW_W'(ROWS)) && (item_q.read_col < COL_W'(COLUMNS));
  end

  // memory write port
  always_comb begin
    wa      = cell_addr;
    wchar   = 8'h00;
    wattr   = cur_attr_i;
    we_char = 1'b0;
    we_attr = 1'b0;
    if (cmd_i.init_wr) begin
      wa      = cnt_q;
      wattr   = RESET_ATTR;
      we_char = 1'b1;
      we_attr = 1'b1;
    end else if (cmd_i.row_clr) begin
      wa      = clr_addr;
      we_char = 1'b1;
      we_attr = 1'b1;
    end else if (cmd_i.exec && !is_read) begin
      wchar   = wr_attr_x ? item_q.byte_in : 8'h00;
      we_char = wr_char_x;
      we_attr = wr_attr_x;
    end
  end

  assign rd_en = cmd_i.exec && is_read && rd_in_range;

  always_ff @(posedge clk_i) begin
    if (we_char) char_mem[wa] <= wchar;
    if (we_attr) attr_mem[wa] <= wattr;
    if (rd_en) begin
      rd_char_q <= char_mem[cell_addr];
      rd_attr_q <= attr_mem[cell_addr];
    end
  end

  // sweep counter, shared by the reset clear and the bottom row fill
  assign cnt_last = (cmd_i.init_wr && cnt_q == ADDR_W'(CELLS - 1)) ||
                    (cmd_i.row_clr && cnt_q == ADDR_W'(COLUMNS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.init_wr || cmd_i.row_clr) begin
      cnt_q <= cnt_last ? '0 : cnt_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) item_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      top_q      <= '0;
      scrolled_q <= 1'b0;
      rng_q      <= 1'b0;
    end else if (cmd_i.exec) begin
      rng_q <= is_read && rd_in_range;
      if (is_read) begin
        scrolled_q <= 1'b0;
      end else begin
        col_q      <= nxt_col;
        row_q      <= scroll ? ROW_W'(ROWS - 1) : nxt_row[ROW_W-1:0];
        scrolled_q <= scroll;
        if (scroll) begin
          top_q <= (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);
        end
      end
    end
  end

  // result register
  always_comb begin
    if (cmd_i.exec) begin
      out_d.cursor_col = nxt_col;
      out_d.cursor_row = nxt_row[ROW_W-1:0];
      out_d.cell_char  = 8'h00;
      out_d.cell_attr  = 8'h00;
      out_d.scrolled   = 1'b0;
    end else begin
      out_d.cursor_col = col_q;
      out_d.cursor_row = row_q;
      out_d.cell_char  = rng_q ? rd_char_q : 8'h00;
      out_d.cell_attr  = rng_q ? rd_attr_q : 8'h00;
      out_d.scrolled   = scrolled_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.is_read  = is_read;
  assign sts_o.scroll   = scroll;
  assign sts_o.cnt_last = cnt_last;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  a_cursor_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < COL_W'(COLUMNS)) && (row_q < ROW_W'(ROWS)))
    else $error("cursor outside the grid");

  a_top_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q < ROW_W'(ROWS))
    else $error("ring top row out of range");

  a_write_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_char || we_attr) |-> (wa < ADDR_W'(CELLS)))
    else $error("memory write beyond the grid");

  a_scroll_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.scrolled) |-> (out_q.cursor_row == ROW_W'(ROWS - 1)))
    else $error("scroll result with cursor off the bottom row");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while held");

endmodule

FILE: hw/rtl/text_console_writer.sv
// Text console with an 80x25 grid of character/attribute cells and a cursor.
// A request either writes one byte (control bytes move the cursor, others are
// stored with current_attr) or reads one cell; every request yields one result
// carrying the cursor position. Timing: a request is accepted, then executed,
// and a write's result is then loaded into the result register; the next
// request can be taken in the cycle that result is offered, so requests do not
// overlap. A read passes through one state more for the registered memory read.
// A write that moves past the last row takes longer before its result and the
// next request: rows are kept as a ring in one cell memory, so a scroll only
// advances the ring and then fills the new bottom row one cell per cycle
// through the single write port. After reset the memory is cleared one cell
// per cycle, during which in_stall_o stays high; register writes are taken
// throughout. A result held by out_stall_i holds the next request at its last
// step.
module text_console_writer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tcw_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tcw_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tcw_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] cur_attr;

  tcw_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cur_attr_o (cur_attr)
  );

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcw_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cur_attr_i  (cur_attr),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
